// ===== hw/rtl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared widths, register indexes and control types for the byte SPN cipher.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int DATA_W    = 8;
    localparam int KEY_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY       = 2'd0,
        CFG_IV        = 2'd1,
        CFG_CHAINING  = 2'd2,
        CFG_DIRECTION = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        MODE_ECB = 1'b0,
        MODE_CBC = 1'b1
    } t_mode;

    typedef enum logic {
        DIR_ENCRYPT = 1'b0,
        DIR_DECRYPT = 1'b1
    } t_dir;

    // Mode control handed from the register bank to the cipher datapath
    typedef struct packed {
        t_mode mode;
        t_dir  dir;
    } t_ctrl;

endpackage

// ===== hw/rtl/bsc_in_if.sv =====
// ----------------------------------------------------------------------------
// bsc_in_if
// Input stream channel: one byte and its start-of-message flag per transaction.
// ----------------------------------------------------------------------------
interface bsc_in_if;
    logic                       valid;
    logic                       ready;
    logic [bsc_pkg::DATA_W-1:0] data_in;
    logic                       start_of_message;

    modport source (output valid, output data_in, output start_of_message, input ready);
    modport sink   (input valid, input data_in, input start_of_message, output ready);
endinterface

// ===== hw/rtl/bsc_out_if.sv =====
// ----------------------------------------------------------------------------
// bsc_out_if
// Output stream channel: one result byte per transaction.
// ----------------------------------------------------------------------------
interface bsc_out_if;
    logic                       valid;
    logic                       ready;
    logic [bsc_pkg::DATA_W-1:0] data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

// ===== hw/rtl/bsc_cipher.sv =====
// ----------------------------------------------------------------------------
// bsc_cipher
// Combinational datapath: CBC mixing plus the four-layer encipher/decipher.
// ----------------------------------------------------------------------------
module bsc_cipher (
    input  logic [bsc_pkg::DATA_W-1:0] i_data,
    input  logic [bsc_pkg::DATA_W-1:0] i_chain,
    input  logic [bsc_pkg::KEY_W-1:0]  i_key,
    input  bsc_pkg::t_ctrl             i_ctrl,
    output logic [bsc_pkg::DATA_W-1:0] o_result,
    output logic [bsc_pkg::DATA_W-1:0] o_chain_next
);

    localparam logic [3:0] INV_SBOX [16] = '{
        4'd15, 4'd6, 4'd13, 4'd4, 4'd11, 4'd2, 4'd9, 4'd0,
        4'd7, 4'd14, 4'd5, 4'd12, 4'd3, 4'd10, 4'd1, 4'd8
    };

    // y = 7(x+1) mod 16
    function automatic logic [3:0] sub_nib(input logic [3:0] x);
        logic [3:0] t;
        t = x + 4'd1;
        return 4'(t * 4'd7);
    endfunction

    function automatic logic [7:0] sub_byte(input logic [7:0] x);
        return {sub_nib(x[7:4]), sub_nib(x[3:0])};
    endfunction

    function automatic logic [7:0] inv_sub_byte(input logic [7:0] x);
        return {INV_SBOX[x[7:4]], INV_SBOX[x[3:0]]};
    endfunction

    function automatic logic [7:0] rotl2(input logic [7:0] x);
        return {x[5:0], x[7:6]};
    endfunction

    function automatic logic [7:0] rotr2(input logic [7:0] x);
        return {x[1:0], x[7:2]};
    endfunction

    logic [7:0] k0, k1, k2, k3;
    logic [7:0] cv;
    logic [7:0] e0, e1, e2, enc;
    logic [7:0] d0, d1, d2, dec;

    assign k0 = i_key[31:24];
    assign k1 = i_key[23:16];
    assign k2 = i_key[15:8];
    assign k3 = i_key[7:0];

    // ECB ignores the chain byte
    assign cv = (i_ctrl.mode == bsc_pkg::MODE_CBC) ? i_chain : 8'd0;

    // Encrypt: whiten, two rounds, final substitution
    assign e0  = i_data ^ cv ^ k0;
    assign e1  = rotl2(sub_byte(e0)) ^ k1;
    assign e2  = rotl2(sub_byte(e1)) ^ k2;
    assign enc = sub_byte(e2) ^ k3;

    // Decrypt: undo the layers in reverse
    assign d0  = inv_sub_byte(i_data ^ k3);
    assign d1  = inv_sub_byte(rotr2(d0 ^ k2));
    assign d2  = inv_sub_byte(rotr2(d1 ^ k1));
    assign dec = d2 ^ k0 ^ cv;

    always_comb begin
        if (i_ctrl.dir == bsc_pkg::DIR_DECRYPT) begin
            o_result     = dec;
            o_chain_next = i_data;
        end else begin
            o_result     = enc;
            o_chain_next = enc;
        end
    end

endmodule

// ===== hw/rtl/byte_spn_cipher_ecb_cbc.sv =====
// ----------------------------------------------------------------------------
// byte_spn_cipher_ecb_cbc
// Byte-wide SPN cipher, ECB or CBC, encrypt or decrypt, one byte per cycle unless the output stalls.
// ----------------------------------------------------------------------------
//
//  Channel  | Port        | Dir | Contents
//  ---------+-------------+-----+-------------------------------------------
//  input    | i_data      | in  | data_in[7:0], start_of_message
//  output   | o_data      | out | data_out[7:0]
//  config   | i_cfg_*     | in  | we, idx[1:0] (key, iv, chaining, dir), wdata[31:0]
//
//  A byte accepted on the input is registered in the input stage; its result
//  is registered in the output register when that stage advances. Throughput
//  is one byte per cycle while the output does not stall, set by the single
//  cipher layer between the input and output registers, which also updates
//  the chain byte so the next byte sees it straight away.
//  Reset (synchronous, active low) clears the valid flags, the chain byte and
//  all configuration registers. A stall on the output holds both stages;
//  ready on the input drops only when both stages are full and stalled.
//
module byte_spn_cipher_ecb_cbc (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bsc_in_if.sink                        i_data,
    bsc_out_if.source                     o_data,
    input  logic                          i_cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bsc_pkg::KEY_W-1:0]     i_cfg_wdata
);

    // Configuration registers
    logic [bsc_pkg::KEY_W-1:0]  r_key;
    logic [bsc_pkg::DATA_W-1:0] r_iv;
    bsc_pkg::t_mode             r_chaining;
    bsc_pkg::t_dir              r_direction;

    // Input stage
    logic                       r_in_valid;
    logic [bsc_pkg::DATA_W-1:0] r_in_data;
    logic                       r_in_som;

    // Output stage and chain state
    logic                       r_out_valid;
    logic [bsc_pkg::DATA_W-1:0] r_out_data;
    logic [bsc_pkg::DATA_W-1:0] r_chain;

    logic                       n_out_valid;
    logic [bsc_pkg::DATA_W-1:0] n_chain;
    logic [bsc_pkg::DATA_W-1:0] w_chain_sel;
    logic [bsc_pkg::DATA_W-1:0] w_result;
    logic                       w_adv;
    logic                       w_in_take;
    bsc_pkg::t_ctrl             w_ctrl;

    // ------------------------------------------------------------------
    // Configuration writes; every index is decoded, none falls to the default arm
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '0;
            r_iv        <= '0;
            r_chaining  <= bsc_pkg::MODE_ECB;
            r_direction <= bsc_pkg::DIR_ENCRYPT;
        end else if (i_cfg_we) begin
            case (bsc_pkg::t_cfg_idx'(i_cfg_idx))
                bsc_pkg::CFG_KEY:       r_key       <= i_cfg_wdata;
                bsc_pkg::CFG_IV:        r_iv        <= i_cfg_wdata[bsc_pkg::DATA_W-1:0];
                bsc_pkg::CFG_CHAINING:  r_chaining  <= bsc_pkg::t_mode'(i_cfg_wdata[0]);
                bsc_pkg::CFG_DIRECTION: r_direction <= bsc_pkg::t_dir'(i_cfg_wdata[0]);
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: advance the input stage whenever the output register is
    // empty or being drained this cycle
    // ------------------------------------------------------------------
    assign w_adv          = r_in_valid && (!r_out_valid || o_data.ready);
    assign i_data.ready   = !r_in_valid || w_adv;
    assign w_in_take      = i_data.valid && i_data.ready;
    assign o_data.valid   = r_out_valid;
    assign o_data.data_out = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_data.ready) begin
            r_in_valid <= i_data.valid;
        end
    end

    // Payload: capture only on a transaction
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_data <= i_data.data_in;
            r_in_som  <= i_data.start_of_message;
        end
    end

    // ------------------------------------------------------------------
    // Cipher layer; start of message reloads the chain from the IV first
    // ------------------------------------------------------------------
    assign w_chain_sel = r_in_som ? r_iv : r_chain;
    assign w_ctrl      = '{mode: r_chaining, dir: r_direction};

    bsc_cipher u_cipher (
        .i_data       (r_in_data),
        .i_chain      (w_chain_sel),
        .i_key        (r_key),
        .i_ctrl       (w_ctrl),
        .o_result     (w_result),
        .o_chain_next (n_chain)
    );

    always_comb begin
        if (w_adv) begin
            n_out_valid = 1'b1;
        end else if (o_data.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_chain     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            // Chain tracks every byte, also in ECB
            if (w_adv) begin
                r_chain <= n_chain;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= w_result;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A stalled output must hold the pending input byte
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !o_data.ready |=> r_in_valid)
        else $error("input stage dropped a byte under output stall");

    // Encrypt: chain follows the ciphertext just produced
    a_chain_enc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && (r_direction == bsc_pkg::DIR_ENCRYPT) |=> r_chain == r_out_data)
        else $error("chain byte differs from last ciphertext");

    // Decrypt: chain follows the incoming ciphertext
    a_chain_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && (r_direction == bsc_pkg::DIR_DECRYPT) |=> r_chain == $past(r_in_data))
        else $error("chain byte differs from last input ciphertext");

    // Every accepted byte lands in the input stage
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> r_in_valid && r_in_data == $past(i_data.data_in))
        else $error("accepted byte not registered");

endmodule
